// ----- hw/rtl/piecewise_linear_table_interp_unit_defines.svh -----
// ----------------------------------------------------------------------------
// piecewise linear table interpolation unit: assertion macros
// shared helpers for the concurrent checks on the unit's ports
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PLTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PLTI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/plti_pkg.sv -----
// ----------------------------------------------------------------------------
// plti_pkg
// operation codes, status codes and controller states of the interp unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// operation carried in the input tuser
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// status carried in the output tuser
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_FIRST,
		S_CHECK,
		S_WALK,
		S_MUL,
		S_DIV_START,
		S_DIV_WAIT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/piecewise_linear_table_interp_unit.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit
// Breakpoint table of (angle, radius) pairs with append, clear and query.
// Items are handled one at a time: a new item is taken only once the result
// of the last one has been loaded into the output register. Append, clear,
// no-op and a query on an empty table go straight to the result load. A query
// reads the first and last breakpoints and ends there when the angle falls at
// or beyond either end of the table. Otherwise the walk reads one breakpoint
// per cycle through the single read port of the breakpoint memory until an
// interval holds the angle or the table ends; a query that finds no interval
// or an interval of zero width ends there, and a hit goes on to the multiply,
// the divider start, the bit-serial divider and the result load. A finished
// result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int ANGLE_BITS  = 16,
	parameter int RADIUS_BITS = 32
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       s_tvalid,
	output logic                                            s_tready,
	// angle, radius_in
	input  wire logic [((ANGLE_BITS+RADIUS_BITS+7)/8)*8-1:0] s_tdata,
	// operation
	input  wire logic [plti_pkg::OP_W-1:0]                  s_tuser,
	output logic                                            m_tvalid,
	input  wire logic                                       m_tready,
	// radius_out
	output logic      [((RADIUS_BITS+7)/8)*8-1:0]           m_tdata,
	// status
	output logic      [plti_pkg::STATUS_W-1:0]              m_tuser
);

	import plti_pkg::*;

	localparam int AW         = $clog2(TABLE_DEPTH);
	localparam int CW         = $clog2(TABLE_DEPTH + 1);
	localparam int EW         = ANGLE_BITS + RADIUS_BITS;
	localparam int PW         = RADIUS_BITS + ANGLE_BITS;
	localparam int OUT_DATA_W = ((RADIUS_BITS + 7) / 8) * 8;

	state_t                 state_q, state_d;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          idx_q;
	logic                   m_tvalid_q;
	logic [RADIUS_BITS-1:0] m_radius_q;
	status_t                m_status_q;

	logic [ANGLE_BITS-1:0]  q_angle_q;
	logic [ANGLE_BITS-1:0]  prev_a_q;
	logic [RADIUS_BITS-1:0] prev_r_q;
	logic [RADIUS_BITS-1:0] res_radius_q;
	status_t                res_status_q;
	logic [RADIUS_BITS-1:0] lo_q;
	logic [RADIUS_BITS-1:0] d_q;
	logic                   up_q;
	logic [ANGLE_BITS-1:0]  num_q;
	logic [ANGLE_BITS-1:0]  den_q;
	logic [PW-1:0]          prod_q;

	op_t                    in_op;
	logic [ANGLE_BITS-1:0]  in_angle;
	logic [RADIUS_BITS-1:0] in_radius;
	logic                   in_accept;
	logic                   tbl_full;
	logic                   tbl_empty;

	logic                   ram_we;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;
	logic [ANGLE_BITS-1:0]  rd_a;
	logic [RADIUS_BITS-1:0] rd_r;

	logic                   chk_low;
	logic                   chk_high;
	logic                   walk_hit;
	logic                   walk_end;
	logic [ANGLE_BITS-1:0]  walk_den;

	logic                   div_start;
	logic                   div_done;
	logic [RADIUS_BITS-1:0] div_quo;
	logic                   out_load;

	// input unpacking
	assign in_op     = op_t'(s_tuser);
	assign in_angle  = s_tdata[ANGLE_BITS-1:0];
	assign in_radius = s_tdata[EW-1:ANGLE_BITS];
	assign in_accept = s_tvalid && s_tready;
	assign tbl_full  = (cnt_q == CW'(TABLE_DEPTH));
	assign tbl_empty = (cnt_q == '0);

	// breakpoint memory: angle in the low bits, radius above
	assign ram_we = in_accept && (in_op == OP_APPEND) && !tbl_full;

	plti_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata({in_radius, in_angle}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_a = ram_rdata[ANGLE_BITS-1:0];
	assign rd_r = ram_rdata[EW-1:ANGLE_BITS];

	// end checks against first and last breakpoint, interval test in the walk
	assign chk_low  = (q_angle_q <= prev_a_q);
	assign chk_high = (q_angle_q >= rd_a);
	assign walk_hit = (q_angle_q >= prev_a_q) && (q_angle_q <= rd_a);
	assign walk_end = ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign walk_den = rd_a - prev_a_q;

	// serial divider for the interpolation fraction
	plti_div #(
		.DW(ANGLE_BITS),
		.QW(RADIUS_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.prod  (prod_q),
		.den   (den_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (in_op == OP_QUERY && !tbl_empty) begin
						state_d = S_RD_FIRST;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RD_FIRST: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (chk_low || chk_high) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (walk_hit) begin
					state_d = (walk_den == '0) ? S_DONE : S_MUL;
				end else if (walk_end) begin
					state_d = S_DONE;
				end
			end
			S_MUL: begin
				state_d = S_DIV_START;
			end
			S_DIV_START: begin
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state outputs: ready, memory read address, divider start, result load
	always_comb begin
		s_tready  = 1'b0;
		ram_raddr = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_RD_FIRST: begin
				ram_raddr = AW'(cnt_q - CW'(1));
			end
			S_CHECK: begin
				ram_raddr = AW'(1);
			end
			S_WALK: begin
				ram_raddr = idx_q + AW'(1);
			end
			S_DIV_START: begin
				div_start = 1'b1;
			end
			S_DONE: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept && in_op == OP_APPEND && !tbl_full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (in_accept && in_op == OP_CLEAR) begin
				cnt_q <= '0;
			end
			if (state_q == S_CHECK) begin
				idx_q <= AW'(1);
			end else if (state_q == S_WALK) begin
				idx_q <= idx_q + AW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					q_angle_q    <= in_angle;
					res_radius_q <= '0;
					if (in_op == OP_APPEND && tbl_full) begin
						res_status_q <= STAT_FULL;
					end else if (in_op == OP_QUERY && tbl_empty) begin
						res_status_q <= STAT_EMPTY;
					end else begin
						res_status_q <= STAT_OK;
					end
				end
			end
			S_RD_FIRST: begin
				prev_a_q <= rd_a;
				prev_r_q <= rd_r;
			end
			S_CHECK: begin
				if (chk_low) begin
					res_radius_q <= prev_r_q;
				end else if (chk_high) begin
					res_radius_q <= rd_r;
				end
			end
			S_WALK: begin
				if (walk_hit) begin
					res_radius_q <= prev_r_q;
					lo_q         <= prev_r_q;
					up_q         <= (rd_r >= prev_r_q);
					d_q          <= (rd_r >= prev_r_q) ? (rd_r - prev_r_q) : (prev_r_q - rd_r);
					num_q        <= q_angle_q - prev_a_q;
					den_q        <= walk_den;
				end else begin
					prev_a_q <= rd_a;
					prev_r_q <= rd_r;
					if (walk_end) begin
						res_status_q <= STAT_NOT_FOUND;
					end
				end
			end
			S_MUL: begin
				prod_q <= PW'(d_q) * PW'(num_q);
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					res_radius_q <= up_q ? (lo_q + div_quo) : (lo_q - div_quo);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_radius_q <= res_radius_q;
			m_status_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(m_radius_q);
	assign m_tuser  = m_status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/plti_ram.sv -----
// ----------------------------------------------------------------------------
// plti_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plti_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/plti_div.sv -----
// ----------------------------------------------------------------------------
// plti_div
// bit-serial restoring divider for floor(prod / den) with prod < den * 2^QW
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plti_div #(
	parameter int DW = 16,
	parameter int QW = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [QW+DW-1:0] prod,
	input  wire logic [DW-1:0]    den,
	output logic                  done,
	output logic      [QW-1:0]    quo
);

	localparam int CNT_W = $clog2(QW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [QW-1:0]    sh_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             ge;

	// one quotient digit per cycle
	assign trial = {rem_q, sh_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// partial remainder and dividend / quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[QW+DW-1:QW];
			sh_q  <= prod[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

`default_nettype wire

// ----- hw/rtl/plti_chk.sv -----
// ----------------------------------------------------------------------------
// plti_chk
// port-level checks of the interp unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_linear_table_interp_unit_defines.svh"

module plti_chk #(
	parameter int ANGLE_BITS  = 16,
	parameter int RADIUS_BITS = 32
) (
	input wire logic                                        clk,
	input wire logic                                        arst_n,
	input wire logic                                        s_tvalid,
	input wire logic                                        s_tready,
	input wire logic [((ANGLE_BITS+RADIUS_BITS+7)/8)*8-1:0] s_tdata,
	input wire logic [plti_pkg::OP_W-1:0]                   s_tuser,
	input wire logic                                        m_tvalid,
	input wire logic                                        m_tready,
	input wire logic [((RADIUS_BITS+7)/8)*8-1:0]            m_tdata,
	input wire logic [plti_pkg::STATUS_W-1:0]               m_tuser
);

	import plti_pkg::*;

	logic in_item;
	logic err_result;

	assign in_item    = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);
	assign err_result = (m_tuser == STAT_EMPTY) || (m_tuser == STAT_NOT_FOUND) ||
	                    (m_tuser == STAT_FULL);

	// a stalled result holds
	`PLTI_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// error results carry a zero radius
	`PLTI_ASSERT_IMP(a_err_zero, clk, arst_n, m_tvalid && err_result, m_tdata == '0, "error result with nonzero radius")

	// one item in flight: no accept right after an accept
	`PLTI_ASSERT_NXT(a_one_item, clk, arst_n, in_item, !s_tready, "item accepted while another is in flight")

	// a result shows up only after an item was being worked on
	`PLTI_ASSERT_IMP(a_result_src, clk, arst_n, $rose(m_tvalid), $past(!s_tready), "result without an item in flight")

endmodule

bind piecewise_linear_table_interp_unit plti_chk #(
	.ANGLE_BITS (ANGLE_BITS),
	.RADIUS_BITS(RADIUS_BITS)
) u_plti_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

// ----- dv/piecewise_linear_table_interp_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit_tb
// Self-checking bench for the breakpoint interpolation unit. Items of every
// operation are streamed in with random gaps while the result side stalls at
// random; a local table model predicts radius and status of each item, and
// every result is compared in order against what that model expects.
// ----------------------------------------------------------------------------

module piecewise_linear_table_interp_unit_tb;

	import plti_pkg::*;

	localparam int DEPTH      = 64;
	localparam int IDLE_PCT   = 32;
	localparam int TAIL_WAIT  = 150;

	typedef struct {
		logic [31:0] radius;
		status_t     status;
	} lookup_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // angle [15:0], radius_in [47:16]
	logic [1:0]  s_tuser;   // operation
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // radius_out
	logic [1:0]  m_tuser;   // status

	// local copy of the breakpoint table
	logic [15:0] bp_angle [DEPTH];
	logic [31:0] bp_radius[DEPTH];
	int unsigned bp_count;

	lookup_result_t pending_lookups[$];
	lookup_result_t head_lookup;

	bit          calm;
	int unsigned mismatches;
	int unsigned total_items, n_appends, n_full, n_queries, n_empty, n_interp;
	int unsigned n_clears, n_nops, n_checked;

	piecewise_linear_table_interp_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// linear interpolation inside interval idx, fraction truncated toward the first radius
	function automatic logic [31:0] interp_radius(int unsigned idx, logic [15:0] q);
		logic [63:0] den, num, diff, quo;
		den = 64'(bp_angle[idx + 1]) - 64'(bp_angle[idx]);
		num = 64'(q) - 64'(bp_angle[idx]);
		if (den == 0)
			return bp_radius[idx];
		if (bp_radius[idx + 1] >= bp_radius[idx]) begin
			diff = 64'(bp_radius[idx + 1]) - 64'(bp_radius[idx]);
			quo  = (diff * num) / den;
			return bp_radius[idx] + quo[31:0];
		end
		diff = 64'(bp_radius[idx]) - 64'(bp_radius[idx + 1]);
		quo  = (diff * num) / den;
		return bp_radius[idx] - quo[31:0];
	endfunction

	// apply one item to the table copy and return what the unit should answer
	function automatic lookup_result_t table_step(op_t op, logic [15:0] ang, logic [31:0] rad);
		lookup_result_t res;
		res.radius = '0;
		res.status = STAT_OK;
		case (op)
			OP_APPEND: begin
				n_appends++;
				if (bp_count >= DEPTH) begin
					res.status = STAT_FULL;
					n_full++;
				end else begin
					bp_angle[bp_count]  = ang;
					bp_radius[bp_count] = rad;
					bp_count++;
				end
			end
			OP_QUERY: begin
				n_queries++;
				if (bp_count == 0) begin
					res.status = STAT_EMPTY;
					n_empty++;
				end else if (ang <= bp_angle[0]) begin
					res.radius = bp_radius[0];
				end else if (ang >= bp_angle[bp_count - 1]) begin
					res.radius = bp_radius[bp_count - 1];
				end else begin
					res.status = STAT_NOT_FOUND;
					for (int unsigned i = 0; i + 1 < bp_count; i++) begin
						if (ang >= bp_angle[i] && ang <= bp_angle[i + 1]) begin
							res.radius = interp_radius(i, ang);
							res.status = STAT_OK;
							n_interp++;
							break;
						end
					end
				end
			end
			OP_CLEAR: begin
				n_clears++;
				bp_count = 0;
			end
			default: n_nops++;
		endcase
		return res;
	endfunction

	function automatic logic [15:0] rand_angle();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return 16'h0000;
		if (pick < 10)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_radius();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return 32'h0000_0000;
		if (pick < 16)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// send one item; valid stays high afterwards until the next call or release
	task automatic send_item(input op_t op, input logic [15:0] ang, input logic [31:0] rad);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rad, ang};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_lookups = {pending_lookups, table_step(op, ang, rad)};
		total_items++;
	endtask

	// drop valid and hold off until every pending result has come back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
	endtask

	// result side: random stalls, none during the calm stretch
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch("unexpected result radius", 32'h0, m_tdata);
			end else begin
				head_lookup = pending_lookups.pop_front();
				n_checked++;
				if (m_tdata !== head_lookup.radius)
					report_mismatch("radius_out", head_lookup.radius, m_tdata);
				if (m_tuser !== head_lookup.status)
					report_mismatch("status", 32'(head_lookup.status), 32'(m_tuser));
			end
		end
	end

	// empty table, unused code and clear with nothing stored
	task automatic test_empty_table();
		send_item(OP_QUERY, 16'h0000, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 16'hFFFF, 32'h0000_0000);
		send_item(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_CLEAR, 16'h0000, 32'h0000_0000);
	endtask

	// one entry answers every angle with its radius
	task automatic test_single_entry();
		send_item(OP_APPEND, 16'h8000, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 16'h0000, 32'h0);
		send_item(OP_QUERY, 16'h8000, 32'h0);
		send_item(OP_QUERY, 16'hFFFF, 32'h0);
	endtask

	// full-range intervals, rising and falling
	task automatic test_interp_extremes();
		send_item(OP_CLEAR, 16'h0, 32'h0);
		send_item(OP_APPEND, 16'h0000, 32'h0000_0000);
		send_item(OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 16'h0001, 32'h0);
		send_item(OP_QUERY, 16'h7FFF, 32'h0);
		send_item(OP_QUERY, 16'hFFFE, 32'h0);
		send_item(OP_CLEAR, 16'h0, 32'h0);
		send_item(OP_APPEND, 16'h0000, 32'hFFFF_FFFF);
		send_item(OP_APPEND, 16'hFFFF, 32'h0000_0000);
		send_item(OP_QUERY, 16'h0001, 32'h0);
		send_item(OP_QUERY, 16'h8000, 32'h0);
	endtask

	// repeated angles, and a table appended out of order
	task automatic test_odd_tables();
		send_item(OP_CLEAR, 16'h0, 32'h0);
		send_item(OP_APPEND, 16'd100, 32'd10);
		send_item(OP_APPEND, 16'd200, 32'd20);
		send_item(OP_APPEND, 16'd200, 32'd5000);
		send_item(OP_APPEND, 16'd300, 32'd0);
		send_item(OP_QUERY, 16'd200, 32'h0);
		send_item(OP_QUERY, 16'd250, 32'h0);
		send_item(OP_CLEAR, 16'h0, 32'h0);
		send_item(OP_APPEND, 16'd1000, 32'h0001_0000);
		send_item(OP_APPEND, 16'd300, 32'h0100_0000);
		send_item(OP_APPEND, 16'd2000, 32'h0000_8000);
		send_item(OP_QUERY, 16'd500, 32'h0);
		send_item(OP_QUERY, 16'd1500, 32'h0);
	endtask

	// fill every slot, refuse one more, then walk the longest path
	task automatic test_full_table();
		logic [15:0] last_ang;
		send_item(OP_CLEAR, 16'h0, 32'h0);
		for (int k = 0; k < DEPTH; k++) begin
			last_ang = 16'(k * 1000 + $urandom_range(999));
			send_item(OP_APPEND, last_ang, rand_radius());
		end
		send_item(OP_APPEND, 16'($urandom), $urandom);
		send_item(OP_QUERY, last_ang, 32'h0);
		send_item(OP_QUERY, last_ang - 16'd1, 32'h0);
		send_item(OP_QUERY, 16'd62_500, 32'h0);
		send_item(OP_QUERY, 16'($urandom_range(63_000)), 32'h0);
	endtask

	// rounds of table build-up followed by queries, with some noise mixed in
	task automatic test_random_mix();
		int unsigned stop_at, start_at, n_pts, n_q, pick;
		logic [15:0] pts[$];
		logic [15:0] q, lo_a, hi_a, base;
		bit drained, clustered;
		drained  = 1'b0;
		start_at = total_items;
		stop_at  = total_items + 1600;
		while (total_items < stop_at) begin
			calm = (total_items - start_at >= 500) && (total_items - start_at < 800);
			if (!drained && total_items - start_at >= 1000) begin
				drain_results();
				drained = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 88)
				send_item(OP_CLEAR, 16'($urandom), $urandom);
			else if (pick < 94)
				send_item(OP_NOP, 16'($urandom), $urandom);
			pick = $urandom_range(99);
			if (pick < 70)
				n_pts = $urandom_range(8, 1);
			else if (pick < 95)
				n_pts = $urandom_range(40, 9);
			else
				n_pts = $urandom_range(66, 41);
			clustered = ($urandom_range(3) == 0);
			base = 16'($urandom);
			pts.delete();
			for (int unsigned k = 0; k < n_pts; k++)
				pts = {pts, (clustered ? base + 16'($urandom_range(15)) : rand_angle())};
			if ($urandom_range(9) != 0)
				pts.sort();
			foreach (pts[k])
				send_item(OP_APPEND, pts[k], rand_radius());
			lo_a = pts[0];
			hi_a = pts[pts.size() - 1];
			n_q = $urandom_range(12, 3);
			for (int unsigned k = 0; k < n_q; k++) begin
				pick = $urandom_range(99);
				if (pick < 50)
					q = 16'($urandom_range(hi_a, lo_a));
				else if (pick < 70)
					q = pts[$urandom_range(pts.size() - 1)];
				else if (pick < 85)
					q = rand_angle();
				else
					q = ($urandom_range(1) ? lo_a : hi_a) + 16'($urandom_range(2)) - 16'd1;
				if ($urandom_range(19) == 0)
					send_item(OP_NOP, q, $urandom);
				else
					send_item(OP_QUERY, q, $urandom);
			end
		end
		calm = 1'b0;
	endtask

	// run limit
	initial begin
		#12_000_000;
		$display("timeout with %0d results still pending", pending_lookups.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_NOP;
		m_tready = 1'b0;
		calm     = 1'b0;
		bp_count = 0;
		mismatches  = 0;
		total_items = 0;
		n_appends = 0; n_full = 0; n_queries = 0; n_empty = 0; n_interp = 0;
		n_clears = 0; n_nops = 0; n_checked = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_single_entry();
		test_interp_extremes();
		test_odd_tables();
		drain_results();
		test_full_table();
		drain_results();
		test_random_mix();
		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (pending_lookups.size() != 0)
			mismatches++;

		$display("covered %0d items: %0d appends (%0d refused on a full table), %0d clears, %0d no-ops",
			total_items, n_appends, n_full, n_clears, n_nops);
		$display("%0d queries (%0d on an empty table, %0d interpolated), %0d results checked",
			n_queries, n_empty, n_interp, n_checked);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
